// ===== design/sliding_window_average_macros.svh =====
// Assertion helpers used by sliding_window_average.sv.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define SWA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sliding_window_average: assertion failed");

// The expression must never be true at a clock edge outside reset.
`define SWA_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("sliding_window_average: forbidden condition seen");

`else

`define SWA_ASSERT(lbl, clk, rstn, prop)
`define SWA_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== design/swa_pkg.sv =====
package swa_pkg;

  // Width of the window size register.
  localparam int unsigned WIN_W = 8;
  // Configuration bus.
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INIT_VALUE  = 1'b1;

  localparam int unsigned WIN_RESET = 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_LOAD
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/swa_ring.sv =====
module swa_ring #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/swa_div.sv =====
module swa_div #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W  = 8,
  parameter int unsigned QUOT_W     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic signed [QUOT_W-1:0]     quot_o,
  output swa_pkg::div_stat_t           stat_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]   rem_q, rem_d;
  logic [DIVIDEND_W-1:0]  quo_q, quo_d;
  logic                   neg_q, neg_d;
  logic [QUOT_W-1:0]      res_q, res_d;
  logic [DIVISOR_W:0]     shifted;
  logic [DIVISOR_W:0]     diff;
  logic                   ge;

  // One quotient bit per cycle, restoring, on the magnitude of the dividend.
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntW'(DIVIDEND_W);
      rem_d  = '0;
      neg_d  = dividend_i[DIVIDEND_W-1];
      quo_d  = dividend_i[DIVIDEND_W-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_d = {quo_q[DIVIDEND_W-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
      end else begin
        // Restore the sign; truncation toward zero follows from dividing magnitudes.
        res_d  = neg_q ? (-quo_q[QUOT_W-1:0]) : quo_q[QUOT_W-1:0];
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign quot_o      = $signed(res_q);
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== design/sliding_window_average.sv =====
// Sliding window average: each sample request yields one average request,
// the mean of the last N samples truncated toward zero, N = window size.
// Input channel: sample_i with sample_valid_i / sample_ready_o.
// Output channel: average_o with average_valid_o / average_ready_i.
// Configuration is an APB-style port: window_size at byte address 0 and
// init_value at byte address 4; pready is always high. Either write refills
// the history with init_value and restarts the window, and is meant to be
// issued only while the block is idle.
// Each sample is accepted in S_IDLE, enters the ring and the sum in S_UPDATE
// and is divided in S_START and S_DIV by the bit-serial divider, which
// produces one quotient bit per cycle. The average appears in the same
// cycle that the block raises sample_ready_o again, so a new sample is
// accepted only once the previous average is in the output register.
// The result sits in an output register, so a stalled receiver does not
// block the next sample; only when that register is still full when the
// next division finishes does the block wait, holding its quotient.
// Reset sets window_size to 8 and init_value to 0. The history memory is
// not swept: a fill flag makes entries not yet written in the current lap
// read as init_value, so the block is ready right after reset.
`include "sliding_window_average_macros.svh"

module sliding_window_average #(
  parameter int MAX_WINDOW   = 255,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample channel.
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                                sample_valid_i,
  output logic                                sample_ready_o,
  // Average channel.
  output logic signed [SAMPLE_WIDTH-1:0]      average_o,
  output logic                                average_valid_o,
  input  logic                                average_ready_i,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swa_pkg::PADDR_W-1:0]         paddr,
  input  logic [swa_pkg::PDATA_W-1:0]         pwdata,
  output logic [swa_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned WinW   = swa_pkg::WIN_W;
  localparam int unsigned PdataW = swa_pkg::PDATA_W;
  localparam int unsigned PtrW   = $clog2(MAX_WINDOW + 1);
  // Wide enough for a full window of full-scale samples.
  localparam int unsigned SumW   = SAMPLE_WIDTH + $clog2(MAX_WINDOW + 1);
  localparam int unsigned NReset =
    (MAX_WINDOW < swa_pkg::WIN_RESET) ? MAX_WINDOW : swa_pkg::WIN_RESET;

  swa_pkg::seq_state_e state_q, state_d;

  logic [WinW-1:0]                 win_q, win_d;
  logic signed [SAMPLE_WIDTH-1:0]  init_q, init_d;
  logic [WinW-1:0]                 n_q, n_d;
  logic [PtrW-1:0]                 ptr_q, ptr_d;
  logic                            full_q, full_d;
  logic signed [SumW-1:0]          sum_q, sum_d;
  logic signed [SAMPLE_WIDTH-1:0]  sample_q;
  logic signed [SAMPLE_WIDTH-1:0]  avg_q;
  logic                            avg_valid_q, avg_valid_d;

  logic                            cfg_we;
  logic [swa_pkg::REG_IDX_W-1:0]   cfg_idx;
  logic signed [SumW-1:0]          prod;
  logic [PtrW-1:0]                 nxt;
  logic [SAMPLE_WIDTH-1:0]         ring_rdata;
  logic signed [SAMPLE_WIDTH-1:0]  old;
  logic signed [SumW-1:0]          sum_upd;
  logic                            out_free;

  // Sequencer controls.
  logic                            ring_re;
  logic                            ring_we;
  logic                            upd;
  logic                            div_start;
  logic                            load_out;

  logic signed [SAMPLE_WIDTH-1:0]  div_quot;
  swa_pkg::div_stat_t              div_stat;

  // ---------------------------------------------------------------------
  // Configuration registers. The register index is the word address bit.
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_comb begin
    win_d  = win_q;
    init_d = init_q;
    if (cfg_we) begin
      case (cfg_idx)
        swa_pkg::REG_WINDOW_SIZE: begin
          win_d = pwdata[WinW-1:0];
        end
        swa_pkg::REG_INIT_VALUE: begin
          init_d = $signed(pwdata[SAMPLE_WIDTH-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      swa_pkg::REG_WINDOW_SIZE: prdata = PdataW'(win_q);
      swa_pkg::REG_INIT_VALUE:  prdata = PdataW'($unsigned(init_q));
      default:                  prdata = '0;
    endcase
  end

  // A zero window acts as a window of one; a window above MAX_WINDOW is clamped to it.
  always_comb begin
    if (win_d == '0) begin
      n_d = WinW'(1);
    end else if (32'(win_d) > 32'(MAX_WINDOW)) begin
      n_d = WinW'(MAX_WINDOW);
    end else begin
      n_d = win_d;
    end
  end

  // Starting sum after a refill: every history entry holds init_value.
  assign prod = SumW'(init_d) * SumW'($signed({1'b0, n_d}));

  // ---------------------------------------------------------------------
  // Window bookkeeping. The ring has N+1 entries; the entry after the
  // write pointer is the one that leaves the window.
  // ---------------------------------------------------------------------
  assign nxt = (32'(ptr_q) == 32'(n_q)) ? '0 : ptr_q + PtrW'(1);

  // Entries ahead of the pointer in the first lap were never written and
  // are read as init_value. The entry at index zero is always written by then.
  assign old     = (full_q || (nxt == '0)) ? $signed(ring_rdata) : init_q;
  assign sum_upd = sum_q - SumW'(old) + SumW'(sample_q);

  always_comb begin
    ptr_d  = ptr_q;
    full_d = full_q;
    sum_d  = sum_q;
    if (cfg_we) begin
      ptr_d  = '0;
      full_d = 1'b0;
      sum_d  = prod;
    end else if (upd) begin
      ptr_d = nxt;
      sum_d = sum_upd;
      if (nxt == '0) begin
        full_d = 1'b1;
      end
    end
  end

  swa_ring #(
    .DEPTH  (MAX_WINDOW + 1),
    .ADDR_W (PtrW),
    .DATA_W (SAMPLE_WIDTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i ($unsigned(sample_q)),
    .re_i    (ring_re),
    .raddr_i (nxt),
    .rdata_o (ring_rdata)
  );

  swa_div #(
    .DIVIDEND_W (SumW),
    .DIVISOR_W  (WinW),
    .QUOT_W     (SAMPLE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  // ---------------------------------------------------------------------
  // Sequencer. The old entry is read in the accept cycle, the sum and the
  // ring are updated next, then the divider runs on the registered sum.
  // ---------------------------------------------------------------------
  assign out_free = !avg_valid_q || average_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::S_IDLE: begin
        if (sample_valid_i) begin
          state_d = swa_pkg::S_UPDATE;
        end
      end
      swa_pkg::S_UPDATE: begin
        state_d = swa_pkg::S_START;
      end
      swa_pkg::S_START: begin
        state_d = swa_pkg::S_DIV;
      end
      swa_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_d = out_free ? swa_pkg::S_IDLE : swa_pkg::S_LOAD;
        end
      end
      swa_pkg::S_LOAD: begin
        if (out_free) begin
          state_d = swa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_ready_o = 1'b0;
    ring_re        = 1'b0;
    ring_we        = 1'b0;
    upd            = 1'b0;
    div_start      = 1'b0;
    load_out       = 1'b0;
    case (state_q)
      swa_pkg::S_IDLE: begin
        sample_ready_o = 1'b1;
        ring_re        = sample_valid_i;
      end
      swa_pkg::S_UPDATE: begin
        ring_we = 1'b1;
        upd     = 1'b1;
      end
      swa_pkg::S_START: begin
        div_start = 1'b1;
      end
      swa_pkg::S_DIV: begin
        load_out = div_stat.done && out_free;
      end
      swa_pkg::S_LOAD: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished average waits here for the receiver.
  always_comb begin
    avg_valid_d = avg_valid_q;
    if (load_out) begin
      avg_valid_d = 1'b1;
    end else if (average_ready_i) begin
      avg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swa_pkg::S_IDLE;
      win_q       <= WinW'(swa_pkg::WIN_RESET);
      init_q      <= '0;
      n_q         <= WinW'(NReset);
      ptr_q       <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      avg_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      init_q      <= init_d;
      if (cfg_we) begin
        n_q <= n_d;
      end
      ptr_q       <= ptr_d;
      full_q      <= full_d;
      sum_q       <= sum_d;
      avg_valid_q <= avg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_re) begin
      sample_q <= sample_i;
    end
    if (load_out) begin
      avg_q <= div_quot;
    end
  end

  assign average_o       = avg_q;
  assign average_valid_o = avg_valid_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // A new sample is only taken once the divider has finished the last one.
  `SWA_ASSERT(a_ready_not_busy, clk_i, rst_ni, sample_ready_o |-> !div_stat.busy)
  // The write pointer stays inside the ring of N+1 entries.
  `SWA_ASSERT(a_ptr_in_ring, clk_i, rst_ni, 32'(ptr_q) <= 32'(n_q))
  // Loading the output register always presents a result next cycle.
  `SWA_ASSERT(a_load_shows_result, clk_i, rst_ni, load_out |=> average_valid_o)
  // The divider is never restarted in the middle of a division.
  `SWA_ASSERT_NEVER(a_no_restart_busy, clk_i, rst_ni, div_start && div_stat.busy)

endmodule
